// File: rtl/rstc_pkg.sv
// Shared types, codes and constants for the receive squelch tone controller.
`timescale 1ns / 1ps
`default_nettype none

package rstc_pkg;

   // Tail-tone and no-tone limits: RX ends once a counter passes its limit.
   localparam int unsigned TAIL_TONE_LIMIT = 10;
   localparam int unsigned NO_TONE_LIMIT   = 1000;

   localparam int unsigned TAIL_CNT_W = 8;
   localparam int unsigned NO_TONE_W  = 11;

   // Tone flag bit positions in the status word
   localparam int unsigned FLAG_CTC1  = 10;
   localparam int unsigned FLAG_CTC2  = 11;
   localparam int unsigned FLAG_DCS_N = 14;
   localparam int unsigned FLAG_DCS_I = 15;

   // Signal meter
   localparam logic [8:0]  RSSI_LOW     = 9'd72;
   localparam logic [8:0]  RSSI_HIGH    = 9'd330;
   localparam logic [8:0]  DBM_OFFSET   = 9'd160;
   localparam logic [6:0]  PCT_FULL     = 7'd100;
   // floor(x * 100 / 258) == (x * 812850) >> 21 for x in 0..258
   localparam logic [28:0] PCT_RECIP    = 29'd812850;
   localparam int unsigned PCT_SHIFT    = 21;

   // Configuration register indexes
   localparam logic [0:0] CSR_CODE_TYPE = 1'b0;
   localparam logic [0:0] CSR_MUTE      = 1'b1;

   typedef enum logic [1:0] {
      CODE_OFF   = 2'd0,
      CODE_CTCSS = 2'd1,
      CODE_DCS_N = 2'd2,
      CODE_DCS_I = 2'd3
   } code_type;

   typedef enum logic [1:0] {
      MODE_RX       = 2'd0,
      MODE_INCOMING = 2'd1,
      MODE_TX       = 2'd2,
      MODE_QUIET    = 2'd3
   } radio_mode_type;

   typedef enum logic [1:0] {
      ST_NO   = 2'd0,
      ST_GOT  = 2'd1,
      ST_TAIL = 2'd2
   } tone_status_type;

   typedef enum logic [2:0] {
      ACT_NONE        = 3'd0,
      ACT_KEEP_RX     = 3'd1,
      ACT_END_RX      = 3'd2,
      ACT_END_AUDIO   = 3'd3,
      ACT_START_AUDIO = 3'd4,
      ACT_START_RX    = 3'd5,
      ACT_NOAA_FOUND  = 3'd6
   } action_type;

   typedef struct packed {
      logic [6:0]        power_percent;
      logic signed [8:0] rssi_dbm;
      logic [1:0]        dbm_digits;
   } meter_type;

endpackage

`default_nettype wire

// File: rtl/rstc_meter.sv
// Signal meter: clamped percent, dBm and dBm digit count from a raw RSSI reading.
`timescale 1ns / 1ps
`default_nettype none

module rstc_meter (
   input  wire logic [8:0]        rssi_raw,
   output rstc_pkg::meter_type    meter
);

   logic [8:0]  span;
   logic [28:0] prod;
   logic [8:0]  half;
   logic [7:0]  mag;

   assign span = rssi_raw - rstc_pkg::RSSI_LOW;
   assign prod = 29'(span) * rstc_pkg::PCT_RECIP;
   assign half = {1'b0, rssi_raw[8:1]};

   always_comb begin
      if (rssi_raw < rstc_pkg::RSSI_LOW) begin
         meter.power_percent = '0;
      end else if (rssi_raw > rstc_pkg::RSSI_HIGH) begin
         meter.power_percent = rstc_pkg::PCT_FULL;
      end else begin
         meter.power_percent = prod[rstc_pkg::PCT_SHIFT +: 7];
      end

      meter.rssi_dbm = signed'(half - rstc_pkg::DBM_OFFSET);

      if (half >= rstc_pkg::DBM_OFFSET) begin
         mag = 8'(half - rstc_pkg::DBM_OFFSET);
      end else begin
         mag = 8'(rstc_pkg::DBM_OFFSET - half);
      end

      if (mag < 8'd10) begin
         meter.dbm_digits = 2'd1;
      end else if (mag < 8'd100) begin
         meter.dbm_digits = 2'd2;
      end else begin
         meter.dbm_digits = 2'd3;
      end
   end

endmodule

`default_nettype wire

// File: rtl/receive_squelch_tone_controller.sv
// Top level of the receive squelch tone controller.
`timescale 1ns / 1ps
`default_nettype none

// One check tick per req transfer; one rsp transfer per tick. Throughput is one
// tick per clock unless rsp_tready stalls: a tick is registered on entry, then
// classified and applied to the tail-tone and no-tone counters combinationally,
// and the result is held in an output register that drives rsp_tvalid. The
// counters are updated in the same cycle a tick leaves the input register, so
// consecutive ticks see each other's counter state. Skipped ticks (power save,
// transmitting, quiet) return action none and no tone. Configuration writes are
// always accepted and must only be issued while the block is idle.
module receive_squelch_tone_controller (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] tone_flags, [24:16] rssi_raw, [26:25] radio_mode, [27] reception_active,
   // [28] noaa_mode, [29] monitor_mode, [30] save_mode, [31] modulation_nonzero,
   // [32] meter_due, [39:33] zero
   input  wire logic [39:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] action, [4:3] tone_status, [5] meter_valid, [12:6] power_percent,
   // [21:13] rssi_dbm, [23:22] dbm_digits
   output logic [23:0]      rsp_tdata,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [1:0]  csr_data
);

   // configuration
   rstc_pkg::code_type  code_type_ff;
   logic                mute_ff;

   // input stage
   logic                            in_valid_ff;
   logic [15:0]                     tone_flags_ff;
   logic [8:0]                      rssi_raw_ff;
   rstc_pkg::radio_mode_type        radio_mode_ff;
   logic                            recv_ff;
   logic                            noaa_ff;
   logic                            monitor_ff;
   logic                            save_ff;
   logic                            modnz_ff;
   logic                            due_ff;

   // counters
   logic [rstc_pkg::TAIL_CNT_W-1:0] tail_cnt_ff, tail_cnt_in;
   logic [rstc_pkg::NO_TONE_W-1:0]  no_tone_ff, no_tone_in;

   // result stage
   logic                            out_valid_ff;
   rstc_pkg::action_type            action_ff, action_in;
   rstc_pkg::tone_status_type       status_ff, status_in;
   logic                            mvalid_ff, mvalid_in;
   rstc_pkg::meter_type             meter_ff, meter_in;

   rstc_pkg::meter_type             meter_raw;
   rstc_pkg::tone_status_type       tone_class;
   logic [rstc_pkg::TAIL_CNT_W-1:0] tail_next;
   logic [rstc_pkg::NO_TONE_W-1:0]  no_tone_next;
   logic                            active;
   logic                            advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {meter_ff.dbm_digits, meter_ff.rssi_dbm, meter_ff.power_percent,
                        mvalid_ff, status_ff, action_ff};

   rstc_meter u_meter (
      .rssi_raw (rssi_raw_ff),
      .meter    (meter_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         code_type_ff <= rstc_pkg::CODE_OFF;
         mute_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rstc_pkg::CSR_CODE_TYPE: code_type_ff <= rstc_pkg::code_type'(csr_data);
            rstc_pkg::CSR_MUTE:      mute_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // tone classification
   always_comb begin
      if (noaa_ff) begin
         tone_class = tone_flags_ff[rstc_pkg::FLAG_CTC1] ? rstc_pkg::ST_GOT : rstc_pkg::ST_NO;
      end else if (monitor_ff) begin
         tone_class = rstc_pkg::ST_GOT;
      end else if (tone_flags_ff[rstc_pkg::FLAG_CTC2]) begin
         tone_class = rstc_pkg::ST_TAIL;
      end else if (tone_flags_ff[rstc_pkg::FLAG_CTC1] && code_type_ff == rstc_pkg::CODE_CTCSS) begin
         tone_class = rstc_pkg::ST_GOT;
      end else if (tone_flags_ff[rstc_pkg::FLAG_CTC1] &&
                   (code_type_ff == rstc_pkg::CODE_DCS_N ||
                    code_type_ff == rstc_pkg::CODE_DCS_I || mute_ff)) begin
         tone_class = rstc_pkg::ST_TAIL;
      end else if (tone_flags_ff[rstc_pkg::FLAG_DCS_N] &&
                   (code_type_ff == rstc_pkg::CODE_DCS_N || mute_ff)) begin
         tone_class = rstc_pkg::ST_GOT;
      end else if (tone_flags_ff[rstc_pkg::FLAG_DCS_I] &&
                   code_type_ff == rstc_pkg::CODE_DCS_I) begin
         tone_class = rstc_pkg::ST_GOT;
      end else if (code_type_ff == rstc_pkg::CODE_OFF && !mute_ff) begin
         tone_class = rstc_pkg::ST_GOT;
      end else begin
         tone_class = rstc_pkg::ST_NO;
      end
   end

   // tick evaluation and counter update
   always_comb begin
      active      = !save_ff && radio_mode_ff != rstc_pkg::MODE_TX &&
                    radio_mode_ff != rstc_pkg::MODE_QUIET;
      tail_cnt_in = tail_cnt_ff;
      no_tone_in  = no_tone_ff;
      action_in   = rstc_pkg::ACT_NONE;
      status_in   = rstc_pkg::ST_NO;
      mvalid_in   = 1'b0;
      meter_in    = '0;

      if (tone_class == rstc_pkg::ST_TAIL) begin
         tail_next = (&tail_cnt_ff) ? tail_cnt_ff : tail_cnt_ff + 1'b1;
      end else begin
         tail_next = '0;
      end
      if (tone_class == rstc_pkg::ST_NO && !(&no_tone_ff)) begin
         no_tone_next = no_tone_ff + 1'b1;
      end else begin
         no_tone_next = no_tone_ff;
      end

      if (active) begin
         status_in = tone_class;
         if (radio_mode_ff != rstc_pkg::MODE_INCOMING) begin
            tail_cnt_in = tail_next;
            if (tail_next <= rstc_pkg::TAIL_CNT_W'(rstc_pkg::TAIL_TONE_LIMIT) &&
                no_tone_next <= rstc_pkg::NO_TONE_W'(rstc_pkg::NO_TONE_LIMIT)) begin
               action_in  = rstc_pkg::ACT_KEEP_RX;
               no_tone_in = '0;
               if (due_ff && !recv_ff) begin
                  mvalid_in = 1'b1;
                  meter_in  = meter_raw;
               end
            end else begin
               no_tone_in = no_tone_next;
               action_in  = recv_ff ? rstc_pkg::ACT_END_AUDIO : rstc_pkg::ACT_END_RX;
            end
         end else if (!noaa_ff) begin
            if (recv_ff) begin
               action_in = rstc_pkg::ACT_START_AUDIO;
            end else if ((code_type_ff == rstc_pkg::CODE_OFF && !mute_ff) || modnz_ff ||
                         tone_class == rstc_pkg::ST_GOT) begin
               action_in = rstc_pkg::ACT_START_RX;
            end
         end else if (tone_class == rstc_pkg::ST_GOT) begin
            action_in = rstc_pkg::ACT_NOAA_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tail_cnt_ff  <= '0;
         no_tone_ff   <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            tail_cnt_ff  <= tail_cnt_in;
            no_tone_ff   <= no_tone_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         tone_flags_ff <= req_tdata[15:0];
         rssi_raw_ff   <= req_tdata[24:16];
         radio_mode_ff <= rstc_pkg::radio_mode_type'(req_tdata[26:25]);
         recv_ff       <= req_tdata[27];
         noaa_ff       <= req_tdata[28];
         monitor_ff    <= req_tdata[29];
         save_ff       <= req_tdata[30];
         modnz_ff      <= req_tdata[31];
         due_ff        <= req_tdata[32];
      end
      if (advance) begin
         action_ff <= action_in;
         status_ff <= status_in;
         mvalid_ff <= mvalid_in;
         meter_ff  <= meter_in;
      end
   end

endmodule

`default_nettype wire

// File: test/receive_squelch_tone_controller_tb.sv
// Self-checking testbench for the receive squelch tone controller: directed ticks, then random.
`timescale 1ns / 1ps

module receive_squelch_tone_controller_tb;
   import rstc_pkg::*;

   // Flag bits of a tick, in tdata order above radio_mode
   localparam logic [5:0] B_NONE  = 6'h00;
   localparam logic [5:0] B_RECV  = 6'h01;
   localparam logic [5:0] B_NOAA  = 6'h02;
   localparam logic [5:0] B_MON   = 6'h04;
   localparam logic [5:0] B_SAVE  = 6'h08;
   localparam logic [5:0] B_MODNZ = 6'h10;
   localparam logic [5:0] B_DUE   = 6'h20;

   // Kinds of random tick
   localparam int MIX_NOISE    = 0;
   localparam int MIX_TAIL     = 1;
   localparam int MIX_RX       = 2;
   localparam int MIX_INCOMING = 3;

   typedef struct packed {
      logic           meter_due;
      logic           modulation_nonzero;
      logic           save_mode;
      logic           monitor_mode;
      logic           noaa_mode;
      logic           reception_active;
      radio_mode_type radio_mode;
      logic [8:0]     rssi_raw;
      logic [15:0]    tone_flags;
   } tick_type;

   typedef struct packed {
      logic [1:0]        dbm_digits;
      logic signed [8:0] rssi_dbm;
      logic [6:0]        power_percent;
      logic              meter_valid;
      tone_status_type   tone_status;
      action_type        action;
   } outcome_type;

   typedef struct {
      tick_type    tick;
      int          reps;
      bit          typed;
      outcome_type fixed;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [1:0]  csr_data = '0;

   // Predictor state
   code_type    squelch_code = CODE_OFF;
   logic        mute_on = 1'b0;
   logic [7:0]  tail_run = '0;
   logic [10:0] quiet_run = '0;

   outcome_type outcomes_due[$];
   row_type     directed_rows[$];
   int          fail_count = 0;
   int          ticks_sent = 0;
   int          checked = 0;
   int          settings_seen = 0;
   bit          calm = 1'b0;

   receive_squelch_tone_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic tone_status_type sort_tone(logic [15:0] f, logic noaa, logic mon);
      if (noaa)
         return f[FLAG_CTC1] ? ST_GOT : ST_NO;
      if (mon)
         return ST_GOT;
      if (f[FLAG_CTC2])
         return ST_TAIL;
      if (f[FLAG_CTC1]) begin
         if (squelch_code == CODE_CTCSS)
            return ST_GOT;
         if (squelch_code == CODE_DCS_N || squelch_code == CODE_DCS_I || mute_on)
            return ST_TAIL;
      end
      if (f[FLAG_DCS_N] && (squelch_code == CODE_DCS_N || mute_on))
         return ST_GOT;
      if (f[FLAG_DCS_I] && squelch_code == CODE_DCS_I)
         return ST_GOT;
      if (squelch_code == CODE_OFF && !mute_on)
         return ST_GOT;
      return ST_NO;
   endfunction

   // Advances the counters by one accepted tick and returns its outcome
   function automatic outcome_type tick_outcome(tick_type t);
      outcome_type r;
      int dbm;
      int mag;
      int pct;
      r = '0;
      if (t.save_mode || t.radio_mode == MODE_TX || t.radio_mode == MODE_QUIET)
         return r;
      r.tone_status = sort_tone(t.tone_flags, t.noaa_mode, t.monitor_mode);
      if (t.radio_mode != MODE_INCOMING) begin
         if (r.tone_status == ST_TAIL) begin
            if (tail_run != 8'hFF)
               tail_run++;
         end else begin
            tail_run = '0;
         end
         if (r.tone_status == ST_NO && quiet_run != 11'h7FF)
            quiet_run++;
         if (tail_run <= TAIL_TONE_LIMIT && quiet_run <= NO_TONE_LIMIT) begin
            r.action = ACT_KEEP_RX;
            quiet_run = '0;
            if (t.meter_due && !t.reception_active) begin
               dbm = int'(t.rssi_raw >> 1) - int'(DBM_OFFSET);
               mag = dbm < 0 ? -dbm : dbm;
               if (t.rssi_raw < RSSI_LOW)
                  pct = 0;
               else if (t.rssi_raw > RSSI_HIGH)
                  pct = int'(PCT_FULL);
               else
                  pct = (int'(t.rssi_raw) - int'(RSSI_LOW)) * 100 / 258;
               r.meter_valid   = 1'b1;
               r.power_percent = 7'(pct);
               r.rssi_dbm      = 9'(dbm);
               r.dbm_digits    = mag < 10 ? 2'd1 : (mag < 100 ? 2'd2 : 2'd3);
            end
         end else begin
            r.action = t.reception_active ? ACT_END_AUDIO : ACT_END_RX;
         end
      end else if (!t.noaa_mode) begin
         if (t.reception_active)
            r.action = ACT_START_AUDIO;
         else if ((squelch_code == CODE_OFF && !mute_on) || t.modulation_nonzero
                  || r.tone_status == ST_GOT)
            r.action = ACT_START_RX;
      end else if (r.tone_status == ST_GOT) begin
         r.action = ACT_NOAA_FOUND;
      end
      return r;
   endfunction

   function automatic tick_type mk_tick(logic [15:0] flags, int rssi, radio_mode_type mode,
                                        logic [5:0] bits);
      tick_type t;
      t = {bits, mode, 9'(rssi), flags};
      return t;
   endfunction

   function automatic outcome_type mk_res(action_type a, tone_status_type s, logic mv, int pct,
                                          int dbm, int dig);
      outcome_type r;
      r = {2'(dig), 9'(dbm), 7'(pct), mv, s, a};
      return r;
   endfunction

   function automatic tick_type random_tick(int kind);
      tick_type t;
      int pick;
      t.tone_flags         = 16'($urandom);
      t.radio_mode         = radio_mode_type'($urandom_range(0, 3));
      t.reception_active   = 1'($urandom_range(0, 1));
      t.noaa_mode          = 1'($urandom_range(0, 1));
      t.monitor_mode       = 1'($urandom_range(0, 1));
      t.save_mode          = 1'($urandom_range(0, 1));
      t.modulation_nonzero = 1'($urandom_range(0, 1));
      t.meter_due          = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 7);
      case (pick)
         0: t.rssi_raw = 9'd0;
         1: t.rssi_raw = 9'd511;
         2: t.rssi_raw = 9'($urandom_range(70, 74));
         3: t.rssi_raw = 9'($urandom_range(328, 332));
         default: t.rssi_raw = 9'($urandom);
      endcase
      if (kind != MIX_NOISE)
         t.save_mode = ($urandom_range(0, 11) == 0);
      case (kind)
         MIX_TAIL: begin
            t.radio_mode   = MODE_RX;
            t.save_mode    = 1'b0;
            t.noaa_mode    = 1'b0;
            t.monitor_mode = 1'b0;
            t.tone_flags[FLAG_CTC2] = 1'b1;
         end
         MIX_RX: begin
            t.radio_mode   = MODE_RX;
            t.noaa_mode    = ($urandom_range(0, 5) == 0);
            t.monitor_mode = ($urandom_range(0, 5) == 0);
            t.tone_flags[FLAG_CTC2] = ($urandom_range(0, 3) == 0);
         end
         MIX_INCOMING: begin
            t.radio_mode   = MODE_INCOMING;
            t.noaa_mode    = ($urandom_range(0, 2) == 0);
            t.monitor_mode = ($urandom_range(0, 5) == 0);
         end
         default: ;
      endcase
      return t;
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_tick(tick_type t, bit typed, outcome_type fixed);
      outcome_type predicted;
      if (!calm) begin
         while ($urandom_range(0, 99) < 26) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, t};
      do @(posedge clock); while (!req_tready);
      predicted = tick_outcome(t);
      outcomes_due.push_back(typed ? fixed : predicted);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outcomes_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(logic [0:0] index, logic [1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_CODE_TYPE)
         squelch_code = code_type'(value);
      else
         mute_on = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic add_row(tick_type t, int reps, bit typed, outcome_type fixed);
      row_type r;
      r.tick  = t;
      r.reps  = reps;
      r.typed = typed;
      r.fixed = fixed;
      directed_rows.push_back(r);
   endtask

   always @(negedge clock)
      rsp_tready <= calm || ($urandom_range(0, 99) >= 26);

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (outcomes_due.size() == 0) begin
            $error("response transfer with no tick pending: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = outcomes_due.pop_front();
            checked++;
            check_field("action", int'(want.action), int'(got.action));
            check_field("tone_status", int'(want.tone_status), int'(got.tone_status));
            check_field("meter_valid", int'(want.meter_valid), int'(got.meter_valid));
            check_field("power_percent", int'(want.power_percent), int'(got.power_percent));
            check_field("rssi_dbm", int'(want.rssi_dbm), int'(got.rssi_dbm));
            check_field("dbm_digits", int'(want.dbm_digits), int'(got.dbm_digits));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d responses outstanding", outcomes_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      code_type    code_seq[8];
      logic        mute_seq[8];
      outcome_type none_res;
      int          goal;
      int          pick;
      int          run_len;
      code_seq = '{CODE_OFF, CODE_CTCSS, CODE_DCS_N, CODE_DCS_I,
                   CODE_DCS_I, CODE_OFF, CODE_CTCSS, CODE_DCS_N};
      mute_seq = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
      none_res = '0;

      // Directed ticks, code off and mute off (the reset settings)
      add_row(mk_tick(16'h0800, 0, MODE_RX, B_SAVE), 1, 1, none_res);
      add_row(mk_tick(16'hFFFF, 511, MODE_TX, B_DUE), 1, 1, none_res);
      add_row(mk_tick(16'hFFFF, 511, MODE_QUIET, B_DUE), 1, 1, none_res);
      add_row(mk_tick(16'h0000, 0, MODE_RX, B_DUE), 1, 1,
              mk_res(ACT_KEEP_RX, ST_GOT, 1, 0, -160, 3));
      add_row(mk_tick(16'h0000, 511, MODE_RX, B_DUE), 1, 1,
              mk_res(ACT_KEEP_RX, ST_GOT, 1, 100, 95, 2));
      add_row(mk_tick(16'h0000, 71, MODE_RX, B_DUE), 1, 1,
              mk_res(ACT_KEEP_RX, ST_GOT, 1, 0, -125, 3));
      add_row(mk_tick(16'h0000, 72, MODE_RX, B_DUE), 1, 1,
              mk_res(ACT_KEEP_RX, ST_GOT, 1, 0, -124, 3));
      add_row(mk_tick(16'h0000, 330, MODE_RX, B_DUE), 1, 1,
              mk_res(ACT_KEEP_RX, ST_GOT, 1, 100, 5, 1));
      add_row(mk_tick(16'h0000, 331, MODE_RX, B_DUE), 1, 1,
              mk_res(ACT_KEEP_RX, ST_GOT, 1, 100, 5, 1));
      add_row(mk_tick(16'h0000, 200, MODE_RX, B_DUE), 1, 0, none_res);
      add_row(mk_tick(16'h0000, 300, MODE_RX, B_DUE | B_RECV), 1, 1,
              mk_res(ACT_KEEP_RX, ST_GOT, 0, 0, 0, 0));
      // monitor wins over the tail flag
      add_row(mk_tick(16'h0800, 0, MODE_RX, B_MON), 1, 1, mk_res(ACT_KEEP_RX, ST_GOT, 0, 0, 0, 0));
      add_row(mk_tick(16'hFFFF, 0, MODE_RX, B_NOAA), 1, 1, mk_res(ACT_KEEP_RX, ST_GOT, 0, 0, 0, 0));
      add_row(mk_tick(16'hFBFF, 0, MODE_RX, B_NOAA), 1, 1, mk_res(ACT_KEEP_RX, ST_NO, 0, 0, 0, 0));
      // tail tones: ten are tolerated, the eleventh ends RX
      add_row(mk_tick(16'h0800, 0, MODE_RX, B_NONE), 10, 1,
              mk_res(ACT_KEEP_RX, ST_TAIL, 0, 0, 0, 0));
      add_row(mk_tick(16'h0800, 0, MODE_RX, B_NONE), 1, 1, mk_res(ACT_END_RX, ST_TAIL, 0, 0, 0, 0));
      add_row(mk_tick(16'h0800, 0, MODE_RX, B_RECV), 1, 1,
              mk_res(ACT_END_AUDIO, ST_TAIL, 0, 0, 0, 0));
      // skipped and incoming ticks leave the tail count alone
      add_row(mk_tick(16'h0000, 0, MODE_RX, B_SAVE), 1, 1, none_res);
      add_row(mk_tick(16'h0800, 0, MODE_INCOMING, B_NONE), 1, 1,
              mk_res(ACT_START_RX, ST_TAIL, 0, 0, 0, 0));
      add_row(mk_tick(16'h0800, 0, MODE_RX, B_NONE), 1, 1, mk_res(ACT_END_RX, ST_TAIL, 0, 0, 0, 0));
      add_row(mk_tick(16'h0000, 0, MODE_RX, B_NONE), 1, 1, mk_res(ACT_KEEP_RX, ST_GOT, 0, 0, 0, 0));
      add_row(mk_tick(16'h0000, 0, MODE_INCOMING, B_RECV), 1, 1,
              mk_res(ACT_START_AUDIO, ST_GOT, 0, 0, 0, 0));
      add_row(mk_tick(16'h0400, 0, MODE_INCOMING, B_NOAA), 1, 1,
              mk_res(ACT_NOAA_FOUND, ST_GOT, 0, 0, 0, 0));
      add_row(mk_tick(16'hFBFF, 0, MODE_INCOMING, B_NOAA), 1, 1, none_res);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         repeat (directed_rows[i].reps)
            send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].fixed);

      for (int p = 0; p < 8; p++) begin
         drain();
         // the setting with the long saturating tail run is also the stretch without idling
         calm = (p == 3);
         csr_write(CSR_CODE_TYPE, 2'(code_seq[p]));
         csr_write(CSR_MUTE, {1'b0, mute_seq[p]});
         settings_seen++;
         goal = ticks_sent + 15;
         while (ticks_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               run_len = $urandom_range(6, 14);
               repeat (run_len) begin
                  if ($urandom_range(0, 9) == 0)
                     send_tick(random_tick($urandom_range(0, 1) ? MIX_INCOMING : MIX_NOISE),
                               0, none_res);
                  send_tick(random_tick(MIX_TAIL), 0, none_res);
               end
            end else if (pick < 75) begin
               send_tick(random_tick(MIX_RX), 0, none_res);
            end else if (pick < 88) begin
               send_tick(random_tick(MIX_INCOMING), 0, none_res);
            end else begin
               send_tick(random_tick(MIX_NOISE), 0, none_res);
            end
         end
         // one long tail run drives the tail counter into saturation
         if (p == 3) begin
            repeat (262)
               send_tick(random_tick(MIX_TAIL), 0, none_res);
            send_tick(random_tick(MIX_RX), 0, none_res);
         end
      end

      drain();
      repeat (8) @(negedge clock);
      $display("Run covered %0d ticks under %0d squelch settings, %0d responses checked",
               ticks_sent, settings_seen + 1, checked);
      $display("including tail-tone runs up to counter saturation and all meter clamp edges");
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: files.f
rtl/rstc_pkg.sv
rtl/rstc_meter.sv
rtl/receive_squelch_tone_controller.sv
test/receive_squelch_tone_controller_tb.sv
